// ===== rtl/flfr_pkg.sv =====
// Shared types and constants of the fixed-length frame receiver.
package flfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int ROUTE_W = 2;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 8'd1;

    // Route codes
    localparam logic [ROUTE_W-1:0] ROUTE_NONE   = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_FIRST  = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_SECOND = 2'd2;

    // Index of the route byte within a frame
    localparam logic [BYTE_W-1:0] ROUTE_POS = 8'd2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_START  = 3'd1,
        ST_STORED = 3'd2,
        ST_DONE   = 3'd3,
        ST_ERROR  = 3'd4
    } t_status;

    // One classified beat travelling from front to back
    typedef struct packed {
        t_status             status;
        logic [BYTE_W-1:0]   position;
        logic [BYTE_W-1:0]   data_byte;
        logic [ROUTE_W-1:0]  route;
    } t_entry;

endpackage

// ===== rtl/flfr_front.sv =====
// Front end: frame tracking and classification of each received byte.
module flfr_front #(
    parameter int FRAME_LEN = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [flfr_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic [flfr_pkg::BYTE_W-1:0] i_start_byte,
    input  logic [flfr_pkg::BYTE_W-1:0] i_end_byte,
    output flfr_pkg::t_entry           o_entry
);

    localparam logic [flfr_pkg::BYTE_W-1:0] LAST_POS = flfr_pkg::BYTE_W'(FRAME_LEN - 1);

    logic                          r_receiving, n_receiving;
    logic [flfr_pkg::BYTE_W-1:0]   r_byte_index, n_byte_index;
    logic [flfr_pkg::ROUTE_W-1:0]  r_route, n_route;
    logic [flfr_pkg::BYTE_W-1:0]   w_idx_inc;

    assign w_idx_inc = r_byte_index + 1'b1;

    always_comb begin
        n_receiving  = r_receiving;
        n_byte_index = r_byte_index;
        n_route      = r_route;
        o_entry.status    = flfr_pkg::ST_IDLE;
        o_entry.position  = '0;
        o_entry.data_byte = i_rx_byte;
        if (r_receiving) begin
            o_entry.position = w_idx_inc;
            if (w_idx_inc == LAST_POS) begin
                o_entry.status = (i_rx_byte == i_end_byte) ? flfr_pkg::ST_DONE
                                                            : flfr_pkg::ST_ERROR;
                n_receiving  = 1'b0;
                n_byte_index = '0;
            end else begin
                if (w_idx_inc == flfr_pkg::ROUTE_POS) begin
                    if (i_rx_byte == flfr_pkg::BYTE_W'(flfr_pkg::ROUTE_FIRST)) begin
                        n_route = flfr_pkg::ROUTE_FIRST;
                    end else if (i_rx_byte == flfr_pkg::BYTE_W'(flfr_pkg::ROUTE_SECOND)) begin
                        n_route = flfr_pkg::ROUTE_SECOND;
                    end
                end
                o_entry.status = flfr_pkg::ST_STORED;
                n_byte_index   = w_idx_inc;
            end
        end else if (i_rx_byte == i_start_byte) begin
            o_entry.status = flfr_pkg::ST_START;
            n_receiving    = 1'b1;
            n_byte_index   = '0;
        end
        // route reported is the one in force after this byte
        o_entry.route = n_route;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving  <= 1'b0;
            r_byte_index <= '0;
            r_route      <= flfr_pkg::ROUTE_NONE;
        end else if (i_accept) begin
            r_receiving  <= n_receiving;
            r_byte_index <= n_byte_index;
            r_route      <= n_route;
        end
    end

endmodule

// ===== rtl/flfr_fifo.sv =====
// Two-entry queue of classified beats between front and back.
module flfr_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  flfr_pkg::t_entry i_entry,
    input  logic             i_pop,
    output flfr_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    flfr_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/flfr_back.sv =====
// Back end: running byte sum, checksum and the output register.
module flfr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  flfr_pkg::t_entry              i_entry,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic [flfr_pkg::BYTE_W-1:0]   o_position,
    output logic [flfr_pkg::BYTE_W-1:0]   o_data_byte,
    output logic [flfr_pkg::ROUTE_W-1:0]  o_route,
    output logic [flfr_pkg::BYTE_W-1:0]   o_checksum
);

    logic                          r_valid;
    logic [flfr_pkg::BYTE_W-1:0]   r_sum, n_sum;
    logic [flfr_pkg::BYTE_W-1:0]   n_checksum;
    flfr_pkg::t_entry              r_entry;
    logic [flfr_pkg::BYTE_W-1:0]   r_checksum;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        n_sum      = r_sum;
        n_checksum = '0;
        unique case (i_entry.status)
            flfr_pkg::ST_START:  n_sum = i_entry.data_byte;
            flfr_pkg::ST_STORED: n_sum = r_sum + i_entry.data_byte;
            flfr_pkg::ST_DONE:   n_checksum = -r_sum;
            default:             n_sum = r_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_sum   <= n_sum;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry    <= i_entry;
            r_checksum <= n_checksum;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = 3'(r_entry.status);
    assign o_position  = r_entry.position;
    assign o_data_byte = r_entry.data_byte;
    assign o_route     = r_entry.route;
    assign o_checksum  = r_checksum;

endmodule

// ===== rtl/fixed_length_frame_receiver.sv =====
// Top level of the fixed-length serial frame receiver with sum checksum.
//
//  Channel | Direction | Handshake                 | Beat contents
//  --------+-----------+---------------------------+--------------------------------
//  rx      | in        | i_rx_valid / o_rx_ready   | i_rx_byte
//  res     | out       | o_res_valid / i_res_ready | status, position, data_byte,
//          |           |                           | route, checksum
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Sustained rate is one rx beat per cycle while results are taken; one
//  result beat per rx beat. The front classifies a beat into the two-entry
//  queue, and the back moves it from there into the registered result.
//  o_rx_ready drops only while the queue holds two beats (result side stalled).
//  Reset (synchronous, active low) idles the frame tracker, clears the route,
//  the running sum, the queue and both configuration registers.
//  Configuration writes are always taken; indexes beyond the list are ignored.
module fixed_length_frame_receiver #(
    parameter int FRAME_LEN = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // received bytes
    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [flfr_pkg::BYTE_W-1:0]   i_rx_byte,
    // results
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [2:0]                    o_status,
    output logic [flfr_pkg::BYTE_W-1:0]   o_position,
    output logic [flfr_pkg::BYTE_W-1:0]   o_data_byte,
    output logic [flfr_pkg::ROUTE_W-1:0]  o_route,
    output logic [flfr_pkg::BYTE_W-1:0]   o_checksum,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [flfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [flfr_pkg::BYTE_W-1:0]   i_cfg_data
);

    localparam logic [flfr_pkg::BYTE_W-1:0] LAST_POS = flfr_pkg::BYTE_W'(FRAME_LEN - 1);

    // configuration registers
    logic [flfr_pkg::BYTE_W-1:0] r_start_byte;
    logic [flfr_pkg::BYTE_W-1:0] r_end_byte;

    logic             w_rx_accept;
    logic             w_full, w_empty, w_pop;
    flfr_pkg::t_entry w_front_entry, w_queue_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
            r_end_byte   <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == flfr_pkg::CFG_START_BYTE) begin
                r_start_byte <= i_cfg_data;
            end else if (i_cfg_index == flfr_pkg::CFG_END_BYTE) begin
                r_end_byte <= i_cfg_data;
            end
        end
    end

    // front takes a beat whenever the queue has room
    assign o_rx_ready  = !w_full;
    assign w_rx_accept = i_rx_valid && o_rx_ready;

    flfr_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_rx_accept),
        .i_rx_byte    (i_rx_byte),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .o_entry      (w_front_entry)
    );

    flfr_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rx_accept),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_entry (w_queue_entry),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back keeps the running sum in beat order and holds the result
    flfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (w_queue_entry),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_res_valid),
        .i_ready     (i_res_ready),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_data_byte (o_data_byte),
        .o_route     (o_route),
        .o_checksum  (o_checksum)
    );

    // checksum is zero on every result except a completed frame
    a_checksum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_status != 3'(flfr_pkg::ST_DONE)) |-> o_checksum == '0)
        else $error("checksum set on a result that is not frame complete");

    // idle and start results sit at position zero
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && ((o_status == 3'(flfr_pkg::ST_IDLE)) ||
                        (o_status == 3'(flfr_pkg::ST_START))) |-> o_position == '0)
        else $error("idle or start result off position zero");

    // frame closes only at the last position
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rx_accept && ((w_front_entry.status == flfr_pkg::ST_DONE) ||
                        (w_front_entry.status == flfr_pkg::ST_ERROR))
        |-> w_front_entry.position == LAST_POS)
        else $error("frame closed away from the last position");

    // a stored byte is never at position zero
    a_stored_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rx_accept && (w_front_entry.status == flfr_pkg::ST_STORED)
        |-> w_front_entry.position != '0)
        else $error("stored byte at position zero");

endmodule
